[rtl/core/kwm_pkg.sv]
package kwm_pkg;

    // Default sizing of the merge
    localparam int MAX_LISTS_DEF  = 8;
    localparam int LIST_DEPTH_DEF = 64;
    localparam int VALUE_BITS_DEF = 16;

    // Fixed field widths
    localparam int ID_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int CFG_BITS    = 4;
    localparam int REM_BITS    = 4;

    // Reset value of the active sequence count
    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = 4'd8;

    // Input actions
    localparam logic ACT_APPEND  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_ID = 2'd3;

endpackage

[rtl/core/k_way_sorted_merge.sv]
// k_way_sorted_merge: merges several ascending sequences into one stream.
// Command channel: start/busy with action, list_id and value. A command is
// taken at a clock edge where start is high and busy is low.
// Result channel: done strobes for one cycle with status, out_value,
// out_source and remaining; the receiver cannot stall it, so each result
// must be captured in the cycle done is high.
// Configuration: cfg_valid/cfg_ready writes active_lists; cfg_ready is
// always high. Write it only while the block is idle.
// Timing: an append or an extract from an empty heap completes in the
// cycle it is taken; done is registered and follows in the next cycle. An
// extract with N heads scans the head memory one entry a cycle through its
// registered read, then reads the sequence store or the last head and
// writes back in the fetch and write states before done. busy drops in the
// cycle done is shown, so the next command may be taken then.
// Reset: asynchronous, active low. Pointers, heap count and head flags
// clear and active_lists returns to 8. The sequence store and head memory
// hold no reset; only entries already written are ever used.
module k_way_sorted_merge #(
    parameter int MAX_LISTS  = kwm_pkg::MAX_LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [kwm_pkg::ID_BITS-1:0]      list_id,
    input  logic [VALUE_BITS-1:0]            value,
    output logic                             done,
    output logic [kwm_pkg::STATUS_BITS-1:0]  status,
    output logic [VALUE_BITS-1:0]            out_value,
    output logic [kwm_pkg::ID_BITS-1:0]      out_source,
    output logic [kwm_pkg::REM_BITS-1:0]     remaining,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kwm_pkg::CFG_BITS-1:0]     cfg_data
);

    localparam int LIST_BITS  = $clog2(MAX_LISTS);
    localparam int CNT_BITS   = $clog2(MAX_LISTS + 1);
    localparam int OFF_BITS   = $clog2(LIST_DEPTH);
    localparam int PTR_BITS   = $clog2(2 * LIST_DEPTH);
    localparam int ENT_BITS   = VALUE_BITS + LIST_BITS;
    localparam int STORE_SIZE = 1 << (LIST_BITS + OFF_BITS);

    localparam logic [PTR_BITS-1:0] DEPTH_P = PTR_BITS'(LIST_DEPTH);
    localparam logic [PTR_BITS-1:0] WRAP_P  = PTR_BITS'(2 * LIST_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] MAX_C   = CNT_BITS'(MAX_LISTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    // Memories
    logic [VALUE_BITS-1:0] store_mem [STORE_SIZE];
    logic [ENT_BITS-1:0]   heap_mem  [MAX_LISTS];

    // Control and per-sequence state
    logic [1:0]                    state_reg, state_next;
    logic [PTR_BITS-1:0]           rp_reg [MAX_LISTS];
    logic [PTR_BITS-1:0]           wp_reg [MAX_LISTS];
    logic [MAX_LISTS-1:0]          flag_reg;
    logic [CNT_BITS-1:0]           count_reg;
    logic [kwm_pkg::CFG_BITS-1:0]  active_reg;
    logic [CNT_BITS-1:0]           idx_reg, idx_next;
    logic [VALUE_BITS-1:0]         best_val_reg, best_val_next;
    logic [LIST_BITS-1:0]          best_src_reg, best_src_next;
    logic [LIST_BITS-1:0]          best_idx_reg, best_idx_next;
    logic                          refill_reg;
    logic [ENT_BITS-1:0]           heap_rd_reg;
    logic [VALUE_BITS-1:0]         store_rd_reg;
    logic                          done_reg;
    logic [kwm_pkg::STATUS_BITS-1:0] status_reg;
    logic [VALUE_BITS-1:0]         out_value_reg;
    logic [LIST_BITS-1:0]          out_src_reg;
    logic [CNT_BITS-1:0]           rem_reg;

    // Datapath
    logic                          take;
    logic [LIST_BITS-1:0]          in_idx;
    logic [LIST_BITS-1:0]          ptr_idx;
    logic [PTR_BITS-1:0]           rp_sel, wp_sel, fill;
    logic [OFF_BITS-1:0]           woff, roff;
    logic                          id_ok;
    logic [LIST_BITS-1:0]          heap_raddr;
    logic [VALUE_BITS-1:0]         e_val;
    logic [LIST_BITS-1:0]          e_src;
    logic                          cmd;

    assign cmd       = start && (state_reg == S_IDLE);
    assign in_idx    = LIST_BITS'(list_id);
    assign ptr_idx   = (state_reg == S_IDLE) ? in_idx : best_src_reg;
    assign rp_sel    = rp_reg[ptr_idx];
    assign wp_sel    = wp_reg[ptr_idx];
    assign fill      = (wp_sel >= rp_sel) ? (wp_sel - rp_sel)
                                          : PTR_BITS'(wp_sel + WRAP_P + 1'b1 - rp_sel);
    assign woff      = OFF_BITS'((wp_sel >= DEPTH_P) ? (wp_sel - DEPTH_P) : wp_sel);
    assign roff      = OFF_BITS'((rp_sel >= DEPTH_P) ? (rp_sel - DEPTH_P) : rp_sel);
    assign id_ok     = (32'(list_id) < 32'(active_reg)) && (32'(list_id) < MAX_LISTS);
    assign e_val     = heap_rd_reg[ENT_BITS-1:LIST_BITS];
    assign e_src     = heap_rd_reg[LIST_BITS-1:0];
    assign take      = (idx_reg == CNT_BITS'(1)) || (e_val < best_val_reg)
                       || ((e_val == best_val_reg) && (e_src < best_src_reg));

    // Head memory read address
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:  heap_raddr = LIST_BITS'(idx_reg);
            S_FETCH: heap_raddr = LIST_BITS'(count_reg - 1'b1);
            default: heap_raddr = '0;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_val_next = best_val_reg;
        best_src_next = best_src_reg;
        best_idx_next = best_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && action == kwm_pkg::ACT_EXTRACT && count_reg != '0)
                begin
                    state_next = S_SCAN;
                    idx_next   = CNT_BITS'(1);
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    best_val_next = e_val;
                    best_src_next = e_src;
                    best_idx_next = LIST_BITS'(idx_reg - 1'b1);
                end
                if (idx_reg < count_reg)
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = S_FETCH;
            end
            S_FETCH: state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            flag_reg   <= '0;
            count_reg  <= '0;
            active_reg <= kwm_pkg::ACTIVE_RESET;
            done_reg   <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++)
            begin
                rp_reg[i] <= '0;
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Strobe done for a quick command or at the end of an extract
            done_reg  <= (cmd && (action == kwm_pkg::ACT_APPEND || count_reg == '0))
                         || (state_reg == S_WRITE);
            if (cfg_valid)
                active_reg <= cfg_data;
            if (cmd && action == kwm_pkg::ACT_APPEND)
            begin
                if (id_ok && !flag_reg[in_idx])
                begin
                    if (count_reg < MAX_C)
                    begin
                        count_reg        <= count_reg + 1'b1;
                        flag_reg[in_idx] <= 1'b1;
                    end
                end
                else if (id_ok && fill < DEPTH_P)
                    wp_reg[in_idx] <= (wp_sel == WRAP_P) ? '0 : wp_sel + 1'b1;
            end
            if (state_reg == S_FETCH)
            begin
                if (fill != '0)
                    rp_reg[best_src_reg] <= (rp_sel == WRAP_P) ? '0 : rp_sel + 1'b1;
                else
                begin
                    flag_reg[best_src_reg] <= 1'b0;
                    count_reg              <= count_reg - 1'b1;
                end
            end
        end
    end

    // Scan and result payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        best_val_reg <= best_val_next;
        best_src_reg <= best_src_next;
        best_idx_reg <= best_idx_next;
        if (state_reg == S_FETCH)
            refill_reg <= (fill != '0);
        if (cmd && action == kwm_pkg::ACT_APPEND)
        begin
            out_value_reg <= '0;
            out_src_reg   <= '0;
            if (!id_ok)
            begin
                status_reg <= kwm_pkg::ST_BAD_ID;
                rem_reg    <= count_reg;
            end
            else if (!flag_reg[in_idx])
            begin
                status_reg <= kwm_pkg::ST_OK;
                rem_reg    <= (count_reg < MAX_C) ? count_reg + 1'b1 : count_reg;
            end
            else
            begin
                status_reg <= (fill < DEPTH_P) ? kwm_pkg::ST_OK : kwm_pkg::ST_FULL;
                rem_reg    <= count_reg;
            end
        end
        if (cmd && action == kwm_pkg::ACT_EXTRACT && count_reg == '0)
        begin
            status_reg    <= kwm_pkg::ST_EMPTY;
            out_value_reg <= '0;
            out_src_reg   <= '0;
            rem_reg       <= count_reg;
        end
        if (state_reg == S_WRITE)
        begin
            status_reg    <= kwm_pkg::ST_OK;
            out_value_reg <= best_val_reg;
            out_src_reg   <= best_src_reg;
            rem_reg       <= count_reg;
        end
    end

    // Head memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd && action == kwm_pkg::ACT_APPEND && id_ok && !flag_reg[in_idx]
            && count_reg < MAX_C)
            heap_mem[LIST_BITS'(count_reg)] <= {value, in_idx};
        else if (state_reg == S_WRITE)
        begin
            if (refill_reg)
                heap_mem[best_idx_reg] <= {store_rd_reg, best_src_reg};
            else
                heap_mem[best_idx_reg] <= heap_rd_reg;
        end
        heap_rd_reg <= heap_mem[heap_raddr];
    end

    // Sequence store: append at the tail, read the oldest value
    always_ff @(posedge clk)
    begin
        if (cmd && action == kwm_pkg::ACT_APPEND && id_ok && flag_reg[in_idx]
            && fill < DEPTH_P)
            store_mem[{in_idx, woff}] <= value;
        store_rd_reg <= store_mem[{best_src_reg, roff}];
    end

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_value  = out_value_reg;
    assign out_source = kwm_pkg::ID_BITS'(out_src_reg);
    assign remaining  = kwm_pkg::REM_BITS'(rem_reg);

endmodule
